@@ rtl/core/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared widths, byte patterns and the result record of the decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CpW   = 21;
	localparam int unsigned PendW = 2;

	localparam int unsigned OqDepth = 4;
	localparam int unsigned OqAw    = $clog2(OqDepth);
	localparam int unsigned OqCntW  = $clog2(OqDepth + 1);

	localparam logic [1:0] ContTag  = 2'b10;
	localparam logic [2:0] Lead2Tag = 3'b110;
	localparam logic [3:0] Lead3Tag = 4'b1110;
	localparam logic [4:0] Lead4Tag = 5'b11110;

	typedef struct packed {
		logic [CpW-1:0] code_point;
		logic           error;
		logic           last;
	} u8d_result_t;

endpackage

@@ rtl/core/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Turns a byte stream into code points, flagging malformed sequences.
// ----------------------------------------------------------------------------
// One byte is taken per request and the decoder sustains one byte per clock
// cycle while the queue has room. A byte is held in the input register and
// is decoded into zero, one or two results that enter a four-entry output
// queue, from which the first result is presented once it is written. A byte
// moves on only while the queue has room for two results, so a stalled consumer
// throttles the input, and the queue depth alone sets how much slack there is.
module utf8_stream_decoder
	import u8d_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ByteW-1:0] in_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CpW-1:0]   code_point,
	output logic             error,
	output logic             last
);

	logic [ByteW-1:0] byte_s1;
	logic             valid_s1;
	logic [PendW-1:0] pending_q;
	logic [CpW-1:0]   partial_q;

	u8d_result_t      oq_q [OqDepth];
	logic [OqAw-1:0]  wr_ptr_q;
	logic [OqAw-1:0]  rd_ptr_q;
	logic [OqCntW-1:0] count_q;

	logic             advance;
	logic             pop;
	logic [1:0]       n_res;
	u8d_result_t      res0;
	u8d_result_t      res1;
	logic [PendW-1:0] pending_d;
	logic [CpW-1:0]   partial_d;
	logic [CpW-1:0]   acc;

	assign advance  = valid_s1 && (count_q <= OqCntW'(OqDepth - 2));
	assign in_ready = !valid_s1 || advance;
	assign pop      = out_valid && out_ready;

	assign acc = {partial_q[CpW-7:0], byte_s1[5:0]};

	always_comb begin
		n_res     = 2'd0;
		res0      = '{code_point: '0, error: 1'b1, last: 1'b1};
		res1      = '{code_point: '0, error: 1'b0, last: 1'b1};
		pending_d = pending_q;
		partial_d = partial_q;
		if (pending_q == '0) begin
			if (!byte_s1[7]) begin
				n_res = 2'd1;
				res0  = '{code_point: CpW'(byte_s1), error: 1'b0, last: 1'b1};
			end else if (byte_s1[7:5] == Lead2Tag) begin
				partial_d = CpW'(byte_s1[4:0]);
				pending_d = PendW'(1);
			end else if (byte_s1[7:4] == Lead3Tag) begin
				partial_d = CpW'(byte_s1[3:0]);
				pending_d = PendW'(2);
			end else if (byte_s1[7:3] == Lead4Tag) begin
				partial_d = CpW'(byte_s1[2:0]);
				pending_d = PendW'(3);
			end else begin
				n_res = 2'd1;
			end
		end else if (byte_s1[7:6] == ContTag) begin
			pending_d = pending_q - PendW'(1);
			if (pending_q == PendW'(1)) begin
				partial_d = '0;
				n_res     = 2'd1;
				res0      = '{code_point: acc, error: 1'b0, last: 1'b1};
			end else begin
				partial_d = acc;
			end
		end else begin
			pending_d = '0;
			partial_d = '0;
			if (byte_s1 == '0) begin
				n_res     = 2'd2;
				res0.last = 1'b0;
			end else begin
				n_res = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			pending_q <= '0;
			partial_q <= '0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			count_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				pending_q <= pending_d;
				partial_q <= partial_d;
				wr_ptr_q  <= wr_ptr_q + OqAw'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OqAw'(1);
			end
			count_q <= count_q + (advance ? OqCntW'(n_res) : '0) - OqCntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
		if (advance && n_res != 2'd0) begin
			oq_q[wr_ptr_q] <= res0;
		end
		if (advance && n_res == 2'd2) begin
			oq_q[wr_ptr_q + OqAw'(1)] <= res1;
		end
	end

	assign out_valid  = (count_q != '0);
	assign code_point = oq_q[rd_ptr_q].code_point;
	assign error      = oq_q[rd_ptr_q].error;
	assign last       = oq_q[rd_ptr_q].last;

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OqCntW'(OqDepth))
		else $error("Output queue count exceeds its depth.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> code_point == '0)
		else $error("An error result carries a nonzero code point.");

	a_not_last_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> error)
		else $error("A result that is not last is not an error.");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && !error && last)
		else $error("The zero result after a broken sequence is missing.");

endmodule
